// ===== src/mfb_pkg.sv =====
package mfb_pkg;

  localparam int unsigned PANEL_WIDTH  = 128;
  localparam int unsigned PANEL_HEIGHT = 64;
  localparam int unsigned PAGE_COUNT   = PANEL_HEIGHT / 8;
  localparam int unsigned STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;
  localparam int unsigned STRIDE       = PANEL_WIDTH / 8;
  localparam int unsigned ADDR_W       = $clog2(STORE_BYTES);

  // widest logical row decides how far a run position can reach
  localparam int unsigned MAX_DIM    = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  localparam int unsigned POS_W      = $clog2(128 * MAX_DIM);
  localparam int unsigned RUN_ADDR_W = POS_W - 3;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_FILL  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef struct packed {
    logic [RUN_ADDR_W-1:0] addr0;
    logic                  ok0;
    logic                  ok1;
    logic [7:0]            mask0;
    logic [7:0]            mask1;
    logic [7:0]            bits0;
    logic [7:0]            bits1;
  } run_plan_t;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    r = {v[3:0], v[7:4]};
    r = ((r << 2) & 8'hCC) | ((r >> 2) & 8'h33);
    r = ((r << 1) & 8'hAA) | ((r >> 1) & 8'h55);
    return r;
  endfunction

endpackage

// ===== src/mfb_run_split.sv =====
module mfb_run_split (
  input  logic [6:0]         pixel_x_i,
  input  logic [6:0]         pixel_y_i,
  input  logic [7:0]         data_byte_i,
  input  logic [3:0]         bit_count_i,
  input  logic [1:0]         rotation_i,
  output mfb_pkg::run_plan_t plan_o
);
  import mfb_pkg::*;

  logic [POS_W-1:0]      row_width;
  logic [POS_W-1:0]      pos;
  logic [3:0]            cnt;
  logic [2:0]            off;
  logic [7:0]            lead;
  logic [15:0]           mask16;
  logic [15:0]           bits16;
  logic [RUN_ADDR_W:0]   addr1_ext;

  always_comb begin
    row_width = rotation_i[0] ? POS_W'(PANEL_HEIGHT) : POS_W'(PANEL_WIDTH);
    pos       = POS_W'(POS_W'(pixel_y_i) * row_width + POS_W'(pixel_x_i));
    cnt       = (bit_count_i > 4'd8) ? 4'd8 : bit_count_i;
    off       = pos[2:0];
    // leading cnt bits of the byte, msb first
    lead      = ~(8'hFF >> cnt);
    mask16    = {lead, 8'h00} >> off;
    bits16    = {data_byte_i & lead, 8'h00} >> off;

    plan_o.addr0 = pos[POS_W-1:3];
    addr1_ext    = {1'b0, pos[POS_W-1:3]} + (RUN_ADDR_W+1)'(1);
    plan_o.ok0   = {1'b0, pos[POS_W-1:3]} < (RUN_ADDR_W+1)'(STORE_BYTES);
    plan_o.ok1   = addr1_ext < (RUN_ADDR_W+1)'(STORE_BYTES);
    plan_o.mask0 = mask16[15:8];
    plan_o.mask1 = mask16[7:0];
    plan_o.bits0 = bits16[15:8];
    plan_o.bits1 = bits16[7:0];
  end

endmodule

// ===== src/mono_framebuffer_page_readout_core.sv =====
// channel   dir  signals                        item
// cfg       in   cfg_we_i, cfg_wdata_i          rotation_mode, no wait
// s_axis    in   tvalid/tready/tdata(40)        action, run, fill or page read
// m_axis    out  tvalid/tready/tdata(8)         page_byte, one per page read
//
// page read: at 0/180 degrees eight rows pass through the one read port of the
// frame memory, at 90/270 a single row; then a gather and an output step.
// bit run: read-modify-write of up to two bytes; fill: writes all 1024 bytes.
// after reset a clearing pass writes zero to all 1024 bytes, one per cycle,
// before the first item is taken; configuration writes are taken throughout.
// a result waiting on m_axis holds the block in its last read step only.
module mono_framebuffer_page_readout_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,     // rotation_mode
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // action[1:0], pixel_x[8:2], pixel_y[15:9], data_byte[23:16],
  // bit_count[27:24], page_index[30:28], column_index[37:31], zero[39:38]
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o   // page_byte
);
  import mfb_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_WR0  = 3'd2;
  localparam logic [2:0] ST_WR1  = 3'd3;
  localparam logic [2:0] ST_WR2  = 3'd4;
  localparam logic [2:0] ST_RD   = 3'd5;
  localparam logic [2:0] ST_RDW  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [1:0] action;
  logic [6:0] pixel_x;
  logic [6:0] pixel_y;
  logic [7:0] data_byte;
  logic [3:0] bit_count;
  logic [2:0] page_index;
  logic [6:0] column_index;

  assign action       = s_axis_tdata_i[1:0];
  assign pixel_x      = s_axis_tdata_i[8:2];
  assign pixel_y      = s_axis_tdata_i[15:9];
  assign data_byte    = s_axis_tdata_i[23:16];
  assign bit_count    = s_axis_tdata_i[27:24];
  assign page_index   = s_axis_tdata_i[30:28];
  assign column_index = s_axis_tdata_i[37:31];

  logic [2:0]        state_q, state_d;
  logic [1:0]        rot_q;
  logic [ADDR_W-1:0] fill_ptr_q, fill_ptr_d;
  logic [7:0]        fill_val_q, fill_val_d;
  run_plan_t         plan_q, plan_d, plan;
  logic [ADDR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0]        sel_q, sel_d;
  logic [2:0]        iss_q, iss_d;
  logic              cap_vld_q, cap_vld_d;
  logic [2:0]        cap_idx_q, cap_idx_d;
  logic [7:0]        acc_q, acc_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_data_q, out_data_d;

  logic              accept;
  logic              out_load;
  logic              off_panel;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] addr1;
  logic [2:0]        last_step;

  logic [7:0]        mem [STORE_BYTES];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, rdata_q;

  mfb_run_split u_run_split (
    .pixel_x_i   (pixel_x),
    .pixel_y_i   (pixel_y),
    .data_byte_i (data_byte),
    .bit_count_i (bit_count),
    .rotation_i  (rot_q),
    .plan_o      (plan)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign off_panel = ({6'd0, page_index} >= 9'(PAGE_COUNT)) ||
                     ({2'd0, column_index} >= 9'(PANEL_WIDTH));
  assign addr1     = ADDR_W'(plan_q.addr0 + RUN_ADDR_W'(1));
  assign last_step = rot_q[0] ? 3'd0 : 3'd7;

  always_comb begin
    unique case (rot_q)
      ROT_0:   base_addr = ADDR_W'(ADDR_W'(PANEL_WIDTH) * ADDR_W'(page_index) +
                                   ADDR_W'(column_index >> 3));
      ROT_180: base_addr = ADDR_W'(ADDR_W'(PANEL_WIDTH) *
                                   (ADDR_W'(PAGE_COUNT - 1) - ADDR_W'(page_index)) +
                                   ((ADDR_W'(PANEL_WIDTH - 1) - ADDR_W'(column_index)) >> 3));
      ROT_90:  base_addr = ADDR_W'(ADDR_W'(PAGE_COUNT) * ADDR_W'(column_index) +
                                   ADDR_W'(PAGE_COUNT - 1) - ADDR_W'(page_index));
      default: base_addr = ADDR_W'(ADDR_W'(PAGE_COUNT) *
                                   (ADDR_W'(PANEL_WIDTH - 1) - ADDR_W'(column_index)) +
                                   ADDR_W'(page_index));
    endcase
  end

  always_comb begin
    state_d     = state_q;
    fill_ptr_d  = fill_ptr_q;
    fill_val_d  = fill_val_q;
    plan_d      = plan_q;
    rd_ptr_d    = rd_ptr_q;
    sel_d       = sel_q;
    iss_d       = iss_q;
    cap_vld_d   = 1'b0;
    cap_idx_d   = cap_idx_q;
    acc_d       = acc_q;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    // row data arrives in the cycle after its read was issued
    if (cap_vld_q) begin
      unique case (rot_q)
        ROT_0:   acc_d[cap_idx_q] = rdata_q[sel_q];
        ROT_180: acc_d[3'd7 - cap_idx_q] = rdata_q[sel_q];
        ROT_90:  acc_d = rdata_q;
        default: acc_d = reverse8(rdata_q);
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action)
            ACT_WRITE: begin
              plan_d  = plan;
              state_d = ST_WR0;
            end
            ACT_FILL: begin
              fill_val_d = data_byte;
              fill_ptr_d = '0;
              state_d    = ST_FILL;
            end
            ACT_READ: begin
              acc_d = '0;
              if (off_panel) begin
                state_d = ST_DONE;
              end else begin
                rd_ptr_d = base_addr;
                sel_d    = (rot_q == ROT_0) ? 3'd7 - column_index[2:0] : column_index[2:0];
                iss_d    = '0;
                state_d  = ST_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        mem_we     = 1'b1;
        mem_waddr  = fill_ptr_q;
        mem_wdata  = fill_val_q;
        fill_ptr_d = ADDR_W'(fill_ptr_q + ADDR_W'(1));
        if (fill_ptr_q == ADDR_W'(STORE_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_WR0: begin
        mem_re    = 1'b1;
        mem_raddr = plan_q.addr0[ADDR_W-1:0];
        state_d   = ST_WR1;
      end
      ST_WR1: begin
        mem_we    = plan_q.ok0;
        mem_waddr = plan_q.addr0[ADDR_W-1:0];
        mem_wdata = (rdata_q & ~plan_q.mask0) | plan_q.bits0;
        mem_re    = 1'b1;
        mem_raddr = addr1;
        state_d   = ST_WR2;
      end
      ST_WR2: begin
        mem_we    = plan_q.ok1;
        mem_waddr = addr1;
        mem_wdata = (rdata_q & ~plan_q.mask1) | plan_q.bits1;
        state_d   = ST_IDLE;
      end
      ST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = rd_ptr_q;
        rd_ptr_d  = ADDR_W'(rd_ptr_q + ADDR_W'(STRIDE));
        cap_vld_d = 1'b1;
        cap_idx_d = iss_q;
        iss_d     = iss_q + 3'd1;
        if (iss_q == last_step) begin
          state_d = ST_RDW;
        end
      end
      ST_RDW: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_data_d  = acc_q;
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      rot_q       <= ROT_0;
      fill_ptr_q  <= '0;
      fill_val_q  <= '0;
      iss_q       <= '0;
      cap_vld_q   <= 1'b0;
      cap_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        rot_q <= cfg_wdata_i;
      end
      fill_ptr_q  <= fill_ptr_d;
      fill_val_q  <= fill_val_d;
      iss_q       <= iss_d;
      cap_vld_q   <= cap_vld_d;
      cap_idx_q   <= cap_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    plan_q     <= plan_d;
    rd_ptr_q   <= rd_ptr_d;
    sel_q      <= sel_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

`ifndef ASSERT_OFF
  // the read-modify-write never reads the byte it writes in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("frame memory read and write collide");

  // at 90 and 270 degrees a page byte is a single stored byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_vld_q && rot_q[0]) |-> (cap_idx_q == 3'd0))
    else $error("extra row gathered for a rotated read");

  // a finished page read always shows up on the output next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (m_axis_tvalid_o && (state_q == ST_IDLE)))
    else $error("page byte not presented");

  // the clearing or fill sweep runs without interruption
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FILL) && (fill_ptr_q != '0)) |-> ($past(state_q) == ST_FILL))
    else $error("fill sweep entered midway");
`endif

endmodule
